[design/matrix_keypad_scanner_core_macros.svh]
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_CORE_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad scanner check failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad scanner check failed");

`else

`define ASSERT_NOW(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/mks_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_pkg
// Types, register codes and key tables shared by the keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF  = 2'd1;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [COUNT_W-1:0] HOLDOFF_RESET  = 16'd200;

    localparam logic [6:0] NO_KEY_CHAR = 7'h21;
    localparam logic [3:0] ROWS_IDLE   = 4'hF;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_DEBOUNCE,
        PH_RELEASE,
        PH_HOLDOFF
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [1:0]           column;
        logic [1:0]           row;
        logic [COUNT_W-1:0]   count;
    } scan_state_t;

    typedef struct packed {
        logic [2:0] drive;
        logic       valid;
        logic [6:0] chr;
    } key_result_t;

    function automatic logic [1:0] next_col(input logic [1:0] col);
        logic [1:0] n;
        n = (col >= 2'd2) ? 2'd0 : col + 2'd1;
        return n;
    endfunction

    function automatic logic [2:0] col_drive(input logic [1:0] col);
        logic [2:0] d;
        case (col)
            2'd0:    d = 3'b110;
            2'd1:    d = 3'b101;
            2'd2:    d = 3'b011;
            default: d = 3'b111;
        endcase
        return d;
    endfunction

    // index is {column, row}
    function automatic logic [6:0] key_ascii(input logic [1:0] col, input logic [1:0] row);
        logic [6:0] c;
        case ({col, row})
            4'd0:    c = 7'h2A; // *
            4'd1:    c = 7'h37; // 7
            4'd2:    c = 7'h34; // 4
            4'd3:    c = 7'h31; // 1
            4'd4:    c = 7'h30; // 0
            4'd5:    c = 7'h38; // 8
            4'd6:    c = 7'h35; // 5
            4'd7:    c = 7'h32; // 2
            4'd8:    c = 7'h23; // #
            4'd9:    c = 7'h39; // 9
            4'd10:   c = 7'h36; // 6
            4'd11:   c = 7'h33; // 3
            default: c = NO_KEY_CHAR;
        endcase
        return c;
    endfunction

endpackage

[design/mks_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_step
// Per-tick next-state and result logic of the keypad scan sequencer.
// ----------------------------------------------------------------------------
module mks_step (
    input  mks_pkg::scan_state_t             state_cur,
    input  logic [3:0]                       rows,
    input  logic [mks_pkg::COUNT_W-1:0]      debounce_ticks,
    input  logic [mks_pkg::COUNT_W-1:0]      holdoff_ticks,
    output mks_pkg::scan_state_t             state_next,
    output mks_pkg::key_result_t             result
);

    logic [1:0] low_row;
    logic       row_low;
    logic       count_zero;

    always_comb
    begin
        if (!rows[0])
            low_row = 2'd0;
        else if (!rows[1])
            low_row = 2'd1;
        else if (!rows[2])
            low_row = 2'd2;
        else
            low_row = 2'd3;
    end

    assign row_low    = !rows[state_cur.row];
    assign count_zero = (state_cur.count == '0);

    always_comb
    begin
        state_next   = state_cur;
        result.valid = 1'b0;
        result.chr   = mks_pkg::NO_KEY_CHAR;
        case (state_cur.phase)
            mks_pkg::PH_SCAN:
            begin
                if (rows == mks_pkg::ROWS_IDLE)
                begin
                    state_next.column = mks_pkg::next_col(state_cur.column);
                end
                else
                begin
                    state_next.row   = low_row;
                    state_next.count = debounce_ticks;
                    state_next.phase = mks_pkg::PH_DEBOUNCE;
                end
            end
            mks_pkg::PH_DEBOUNCE:
            begin
                if (!count_zero)
                begin
                    state_next.count = state_cur.count - 1'b1;
                end
                else if (row_low)
                begin
                    result.valid     = 1'b1;
                    result.chr       = mks_pkg::key_ascii(state_cur.column, state_cur.row);
                    state_next.phase = mks_pkg::PH_RELEASE;
                end
                else
                begin
                    state_next.phase  = mks_pkg::PH_SCAN;
                    state_next.column = mks_pkg::next_col(state_cur.column);
                end
            end
            mks_pkg::PH_RELEASE:
            begin
                if (rows == mks_pkg::ROWS_IDLE)
                begin
                    state_next.count = holdoff_ticks;
                    state_next.phase = mks_pkg::PH_HOLDOFF;
                end
            end
            default:
            begin
                if (!count_zero)
                begin
                    state_next.count = state_cur.count - 1'b1;
                end
                else
                begin
                    state_next.phase  = mks_pkg::PH_SCAN;
                    state_next.column = mks_pkg::next_col(state_cur.column);
                end
            end
        endcase
        result.drive = mks_pkg::col_drive(state_next.column);
    end

endmodule

[design/matrix_keypad_scanner_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core
// 3x4 keypad scanner: one row sample in, one column/key beat out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, row_levels) carries one tick: the
//   active-low rows sampled while the previously reported column was driven.
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   column_drive for the next tick, key_valid and key_char ('!' when no key).
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   debounce_ticks (index 0) and holdoff_ticks (index 1); other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle.
//   Each input beat is registered into the single output register after the step
//   logic and shows in the next cycle; one beat per cycle while out_ready is high.
//   A stalled output holds its beat and blocks new input only while full;
//   in_ready is high whenever the output register is empty or being drained.
//   Reset returns to scanning column 0 with debounce 5 and hold-off 200 ticks
//   and empties the output register.
// ----------------------------------------------------------------------------
`include "matrix_keypad_scanner_core_macros.svh"

module matrix_keypad_scanner_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [3:0]                       row_levels,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       column_drive,
    output logic                             key_valid,
    output logic [6:0]                       key_char,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mks_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mks_pkg::COUNT_W-1:0]      cfg_data
);

    mks_pkg::scan_state_t            state_reg;
    mks_pkg::scan_state_t            state_next;
    mks_pkg::key_result_t            step_result;
    logic [mks_pkg::COUNT_W-1:0]     debounce_reg;
    logic [mks_pkg::COUNT_W-1:0]     holdoff_reg;
    logic                            out_valid_reg;
    mks_pkg::key_result_t            out_reg;
    logic                            in_beat;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    mks_step u_step (
        .state_cur      (state_reg),
        .rows           (row_levels),
        .debounce_ticks (debounce_reg),
        .holdoff_ticks  (holdoff_reg),
        .state_next     (state_next),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase  <= mks_pkg::PH_SCAN;
            state_reg.column <= 2'd0;
            state_reg.row    <= 2'd0;
            state_reg.count  <= '0;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= mks_pkg::DEBOUNCE_RESET;
            holdoff_reg  <= mks_pkg::HOLDOFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mks_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                mks_pkg::CFG_HOLDOFF:  holdoff_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            out_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = out_reg.drive;
    assign key_valid    = out_reg.valid;
    assign key_char     = out_reg.chr;

    `ASSERT_NOW(a_column_range, 1'b1, state_reg.column != 2'd3)
    `ASSERT_NOW(a_ready_when_empty, !out_valid_reg, in_ready)
    `ASSERT_NOW(a_key_has_char, out_valid_reg && key_valid, key_char != mks_pkg::NO_KEY_CHAR)
    `ASSERT_NEXT(a_key_only_from_debounce, in_beat && state_reg.phase != mks_pkg::PH_DEBOUNCE,
                 !key_valid)
    `ASSERT_NEXT(a_report_enters_release, in_beat && step_result.valid,
                 state_reg.phase == mks_pkg::PH_RELEASE)

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x4 keypad scanner core.
// Row samples are fed one beat at a time with random sender gaps and
// receiver stalls. A scanner model in the bench predicts every output
// beat, and the monitor compares the beats field by field. Timing is
// swept across several debounce and hold-off settings, zero among them.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [mks_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mks_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 150;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [3:0]                      row_levels = mks_pkg::ROWS_IDLE;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [2:0]                      column_drive;
    logic                            key_valid;
    logic [6:0]                      key_char;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mks_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mks_pkg::COUNT_W-1:0]     cfg_data = '0;

    // scanner model state and register copies
    mks_pkg::phase_t             kp_phase;
    logic [1:0]                  kp_col;
    logic [1:0]                  kp_row;
    logic [mks_pkg::COUNT_W-1:0] kp_count;
    logic [mks_pkg::COUNT_W-1:0] debounce_len;
    logic [mks_pkg::COUNT_W-1:0] holdoff_len;

    logic [3:0]             pending_rows[$];
    mks_pkg::key_result_t   key_beats_due[$];
    mks_pkg::key_result_t   key_due;

    int  sender_gap;
    int  stall_left;
    int  fail_count = 0;
    int  cycles = 0;
    bit  quiet = 1'b1;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done;

    matrix_keypad_scanner_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_levels   (row_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .key_valid    (key_valid),
        .key_char     (key_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [3:0] rnd4();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [1:0] low_row(input logic [3:0] rows);
        logic [1:0] r_low;
        r_low = 2'd0;
        for (int r = 3; r >= 0; r--)
        begin
            if (!rows[r])
            begin
                r_low = r[1:0];
            end
        end
        return r_low;
    endfunction

    function automatic logic [6:0] key_symbol(input int idx);
        string keys;
        byte   b;
        keys = "*7410852#963";
        b = keys[idx];
        return b[6:0];
    endfunction

    function automatic logic [1:0] col_after(input logic [1:0] col);
        return (col == 2'd2) ? 2'd0 : col + 2'd1;
    endfunction

    task automatic step_scanner(input logic [3:0] rows);
        mks_pkg::key_result_t res;
        res.valid = 1'b0;
        res.chr   = mks_pkg::NO_KEY_CHAR;
        case (kp_phase)
            mks_pkg::PH_SCAN:
            begin
                if (rows == mks_pkg::ROWS_IDLE)
                begin
                    kp_col = col_after(kp_col);
                end
                else
                begin
                    kp_row   = low_row(rows);
                    kp_count = debounce_len;
                    kp_phase = mks_pkg::PH_DEBOUNCE;
                end
            end
            mks_pkg::PH_DEBOUNCE:
            begin
                if (kp_count != 0)
                begin
                    kp_count = kp_count - 1'b1;
                end
                else if (!rows[kp_row])
                begin
                    res.valid = 1'b1;
                    res.chr   = key_symbol(int'(kp_row) + 4 * int'(kp_col));
                    kp_phase  = mks_pkg::PH_RELEASE;
                end
                else
                begin
                    kp_phase = mks_pkg::PH_SCAN;
                    kp_col   = col_after(kp_col);
                end
            end
            mks_pkg::PH_RELEASE:
            begin
                if (rows == mks_pkg::ROWS_IDLE)
                begin
                    kp_count = holdoff_len;
                    kp_phase = mks_pkg::PH_HOLDOFF;
                end
            end
            default:
            begin
                if (kp_count != 0)
                begin
                    kp_count = kp_count - 1'b1;
                end
                else
                begin
                    kp_phase = mks_pkg::PH_SCAN;
                    kp_col   = col_after(kp_col);
                end
            end
        endcase
        res.drive = ~(3'b001 << kp_col);
        key_beats_due.push_back(res);
    endtask

    // row sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            row_levels <= mks_pkg::ROWS_IDLE;
            sender_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                step_scanner(row_levels);
            end
            if (!in_valid || in_ready)
            begin
                if (sender_gap != 0)
                begin
                    in_valid   <= 1'b0;
                    sender_gap <= sender_gap - 1;
                end
                else if (pending_rows.size() != 0)
                begin
                    in_valid   <= 1'b1;
                    row_levels <= pending_rows.pop_front();
                    sender_gap <= (!quiet && $urandom_range(0, 3) == 0) ? gap_len() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (key_beats_due.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    key_due = key_beats_due.pop_front();
                    if (column_drive !== key_due.drive)
                    begin
                        $error("column_drive expected %0h got %0h", key_due.drive, column_drive);
                        fail_count++;
                    end
                    if (key_valid !== key_due.valid)
                    begin
                        $error("key_valid expected %0h got %0h", key_due.valid, key_valid);
                        fail_count++;
                    end
                    if (key_char !== key_due.chr)
                    begin
                        $error("key_char expected %0h got %0h", key_due.chr, key_char);
                        fail_count++;
                    end
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                out_ready      <= 1'b0;
                stall_left     <= LONG_HOLD;
                long_hold_done <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= gap_len() - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // spare indexes go last so a bad decode leaves junk behind
    task automatic write_regs(input logic [mks_pkg::COUNT_W-1:0] deb,
                              input logic [mks_pkg::COUNT_W-1:0] hold,
                              input bit with_spare);
        logic [mks_pkg::CFG_INDEX_W-1:0] idx;
        logic [mks_pkg::COUNT_W-1:0]     val;
        int                              beats;
        beats = with_spare ? 4 : 2;
        for (int k = 0; k < beats; k++)
        begin
            case (k)
                0:
                begin
                    idx = mks_pkg::CFG_DEBOUNCE;
                    val = deb;
                end
                1:
                begin
                    idx = mks_pkg::CFG_HOLDOFF;
                    val = hold;
                end
                2:
                begin
                    idx = CFG_SPARE_LO;
                    val = 16'($urandom);
                end
                default:
                begin
                    idx = CFG_SPARE_HI;
                    val = 16'($urandom);
                end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            if (idx == mks_pkg::CFG_DEBOUNCE)
            begin
                debounce_len = val;
            end
            else if (idx == mks_pkg::CFG_HOLDOFF)
            begin
                holdoff_len = val;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_rows.size() != 0 || in_valid || key_beats_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // mostly whole press sequences, plus bounces and random noise
    task automatic fill_random(input int target);
        int         base;
        logic [3:0] press;
        logic [3:0] held;
        logic [1:0] hit;
        base = pending_rows.size();
        while (pending_rows.size() - base < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 5)) pending_rows.push_back(rnd4());
            end
            else
            begin
                press = 4'($urandom_range(0, 14));
                hit   = low_row(press);
                pending_rows.push_back(press);
                repeat (int'(debounce_len)) pending_rows.push_back(rnd4());
                held = rnd4();
                held[hit] = 1'b0;
                if ($urandom_range(0, 5) == 0)
                begin
                    held[hit] = 1'b1;
                    pending_rows.push_back(held);
                end
                else
                begin
                    pending_rows.push_back(held);
                    repeat ($urandom_range(0, 3))
                    begin
                        held = rnd4();
                        held[hit] = 1'b0;
                        pending_rows.push_back(held);
                    end
                    pending_rows.push_back(mks_pkg::ROWS_IDLE);
                    repeat (int'(holdoff_len) + 1) pending_rows.push_back(rnd4());
                    repeat ($urandom_range(0, 2)) pending_rows.push_back(mks_pkg::ROWS_IDLE);
                end
            end
        end
    endtask

    task automatic run_phase(input logic [mks_pkg::COUNT_W-1:0] deb,
                             input logic [mks_pkg::COUNT_W-1:0] hold,
                             input bit with_spare, input bit with_long_hold);
        write_regs(deb, hold, with_spare);
        fill_random(200);
        if (with_long_hold)
        begin
            long_hold_req = 1'b1;
        end
        wait_idle();
    endtask

    initial
    begin
        kp_phase     = mks_pkg::PH_SCAN;
        kp_col       = 2'd0;
        kp_row       = 2'd0;
        kp_count     = '0;
        debounce_len = mks_pkg::DEBOUNCE_RESET;
        holdoff_len  = mks_pkg::HOLDOFF_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale register values, idle scan only, no gaps or stalls
        write_regs(16'hFFFF, 16'hFFFF, 1'b1);
        repeat (8) pending_rows.push_back(mks_pkg::ROWS_IDLE);
        wait_idle();

        quiet = 1'b0;
        write_regs(16'h0000, 16'h0000, 1'b1);
        // all rows low, single rows, held through release, bounce, idle scan
        pending_rows.push_back(4'h0);
        pending_rows.push_back(4'h0);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'h7);
        pending_rows.push_back(4'h7);
        pending_rows.push_back(4'h5);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'h0);
        pending_rows.push_back(4'hB);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hD);
        pending_rows.push_back(4'hD);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hE);
        pending_rows.push_back(4'hE);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hF);
        pending_rows.push_back(4'hF);
        wait_idle();

        run_phase(16'd0, 16'd0, 1'b0, 1'b0);
        run_phase(16'd1, 16'd2, 1'b0, 1'b1);
        run_phase(16'd3, 16'd0, 1'b1, 1'b0);
        run_phase(16'd0, 16'd4, 1'b0, 1'b0);
        run_phase(mks_pkg::DEBOUNCE_RESET, mks_pkg::HOLDOFF_RESET, 1'b0, 1'b0);
        run_phase(16'd2, 16'd1, 1'b1, 1'b0);
        run_phase(16'd7, 16'd3, 1'b0, 1'b0);

        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[matrix_keypad_scanner_core.f]
+incdir+design
design/mks_pkg.sv
design/mks_step.sv
design/matrix_keypad_scanner_core.sv
tb/tb.sv
